@@ rtl/core/depth_pixel_backprojection_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define DPBP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Same, with a caller-supplied message.
`define DPBP_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

@@ rtl/core/dpbp_pkg.sv @@
package dpbp_pkg;

  localparam int unsigned CoordW    = 12;
  localparam int unsigned DepthW    = 16;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned CenterW   = 13;
  localparam int unsigned InvW      = 24;
  localparam int unsigned LimitW    = 16;
  localparam int unsigned OutCoordW = 32;
  localparam int unsigned ProjShift = 25;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [CenterW-1:0] CenterXRst = 13'd639;
  localparam logic [CenterW-1:0] CenterYRst = 13'd479;
  localparam logic [InvW-1:0]    InvFocalRst = 24'd31957;
  localparam logic [LimitW-1:0]  LimitRst    = 16'd5000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX = 3'd0,
    CfgCenterY = 3'd1,
    CfgInvFx   = 3'd2,
    CfgInvFy   = 3'd3,
    CfgLimit   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CenterW-1:0] center_x_doubled;
    logic [CenterW-1:0] center_y_doubled;
    logic [InvW-1:0]    inv_focal_x;
    logic [InvW-1:0]    inv_focal_y;
    logic [LimitW-1:0]  lateral_limit_mm;
  } cfg_t;

  // Load enables of the two multiply stages.
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

@@ rtl/core/dpbp_cfg_regs.sv @@
module dpbp_cfg_regs
  import dpbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCenterX: cfg_d.center_x_doubled = cfg_data_i[CenterW-1:0];
        CfgCenterY: cfg_d.center_y_doubled = cfg_data_i[CenterW-1:0];
        CfgInvFx:   cfg_d.inv_focal_x      = cfg_data_i[InvW-1:0];
        CfgInvFy:   cfg_d.inv_focal_y      = cfg_data_i[InvW-1:0];
        CfgLimit:   cfg_d.lateral_limit_mm = cfg_data_i[LimitW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x_doubled <= CenterXRst;
      cfg_q.center_y_doubled <= CenterYRst;
      cfg_q.inv_focal_x      <= InvFocalRst;
      cfg_q.inv_focal_y      <= InvFocalRst;
      cfg_q.lateral_limit_mm <= LimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/dpbp_axis.sv @@
// One axis: (2*coord - center2) * depth, then * inverse focal, then floor shift.
module dpbp_axis
  import dpbp_pkg::*;
#(
  parameter int unsigned COORD_USE = 12,
  parameter int unsigned DIFF_W    = 14,
  parameter int unsigned Q_W       = 31
) (
  input  logic                   clk_i,
  input  stage_en_t              en_i,
  input  logic [COORD_USE-1:0]   coord_i,
  input  logic [CenterW-1:0]     center2_i,
  input  logic [DepthW-1:0]      depth_i,
  input  logic [InvW-1:0]        inv_i,
  output logic signed [Q_W-1:0]  q_o
);

  localparam int unsigned P1W = DIFF_W + DepthW + 1;
  localparam int unsigned P2W = P1W + InvW + 1;

  logic signed [DIFF_W-1:0] diff;
  logic signed [P1W-1:0]    prod1_d, prod1_q;
  logic signed [P2W-1:0]    prod2_d, prod2_q;

  assign diff = $signed(DIFF_W'({coord_i, 1'b0})) - $signed(DIFF_W'(center2_i));

  assign prod1_d = P1W'(diff) * $signed(P1W'(depth_i));
  assign prod2_d = P2W'(prod1_q) * $signed(P2W'(inv_i));

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod1_q <= prod1_d;
    end
    if (en_i.s2) begin
      prod2_q <= prod2_d;
    end
  end

  // Arithmetic shift by dropping the low bits rounds toward minus infinity.
  assign q_o = prod2_q[P2W-1:ProjShift];

endmodule

@@ rtl/core/depth_pixel_backprojection.sv @@
// Depth pixel back-projection. Takes one pixel per clock (column, row, depth in mm,
// RGB) and returns one colored 3D point per pixel, in order, through three register
// stages. Stage 1 forms the centered coordinate times depth, stage 2 multiplies by
// the inverse focal length, stage 3 shifts, applies the lateral limit and holds
// the result. X/Y = floor((2*coord - center2) * Z * inv_focal / 2^25); Z is the depth.
// Points with zero depth or X/Y above the lateral limit come out with point_kept
// low and zero coordinates; color always passes through. Throughput is one point
// per clock; each stage only holds when the stage after it is full and stalled, so
// bubbles are squeezed out. The configuration channel is always ready; write it
// only while the pipeline is empty. Unknown register indexes are ignored.
module depth_pixel_backprojection
  import dpbp_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: pixel_column[11:0], pixel_row[23:12], depth_mm[39:24],
  //        red_in[47:40], green_in[55:48], blue_in[63:56]
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [63:0]         s_axis_tdata_i,
  // tdata: point_x_mm[31:0], point_y_mm[63:32], point_z_mm[79:64],
  //        red_out[87:80], green_out[95:88], blue_out[103:96]
  // tuser: point_kept[0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [103:0]        m_axis_tdata_o,
  output logic [0:0]          m_axis_tuser_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CoordUse = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam int unsigned DiffW    = (((CoordUse + 1) > CenterW) ? (CoordUse + 1) : CenterW) + 1;
  localparam int unsigned QW       = DiffW + DepthW + 1 + InvW + 1 - ProjShift;
  localparam int unsigned CmpW     = ((QW > LimitW) ? QW : LimitW) + 1;
  localparam int unsigned ColorsW  = 3 * ColorW;

  cfg_t      cfg;
  stage_en_t en;
  logic      en3;

  logic [CoordW-1:0]  in_col, in_row;
  logic [DepthW-1:0]  in_depth;
  logic [ColorsW-1:0] in_rgb;

  logic               v1_q, v2_q, v3_q;
  logic [DepthW-1:0]  depth1_q, depth2_q;
  logic [ColorsW-1:0] rgb1_q, rgb2_q;

  logic signed [QW-1:0] qx, qy;
  logic                 kept;

  logic [OutCoordW-1:0] x_d, x_q, y_d, y_q;
  logic [DepthW-1:0]    z_d, z_q;
  logic [ColorsW-1:0]   rgb3_q;
  logic                 kept_q;

  assign in_col   = s_axis_tdata_i[11:0];
  assign in_row   = s_axis_tdata_i[23:12];
  assign in_depth = s_axis_tdata_i[39:24];
  assign in_rgb   = s_axis_tdata_i[63:40];

  dpbp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // A stage loads when it is empty or its contents move on.
  assign en3    = !v3_q || m_axis_tready_i;
  assign en.s2  = !v2_q || en3;
  assign en.s1  = !v1_q || en.s2;
  assign s_axis_tready_o = en.s1;

  dpbp_axis #(
    .COORD_USE (CoordUse),
    .DIFF_W    (DiffW),
    .Q_W       (QW)
  ) u_axis_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .coord_i   (in_col[CoordUse-1:0]),
    .center2_i (cfg.center_x_doubled),
    .depth_i   (in_depth),
    .inv_i     (cfg.inv_focal_x),
    .q_o       (qx)
  );

  dpbp_axis #(
    .COORD_USE (CoordUse),
    .DIFF_W    (DiffW),
    .Q_W       (QW)
  ) u_axis_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .coord_i   (in_row[CoordUse-1:0]),
    .center2_i (cfg.center_y_doubled),
    .depth_i   (in_depth),
    .inv_i     (cfg.inv_focal_y),
    .q_o       (qy)
  );

  // Signed compare: negative coordinates never reject.
  assign kept = (depth2_q != '0)
      && !($signed(CmpW'(qx)) > $signed(CmpW'(cfg.lateral_limit_mm)))
      && !($signed(CmpW'(qy)) > $signed(CmpW'(cfg.lateral_limit_mm)));

  // Projection never exceeds 31 bits at these widths, so sign extension suffices.
  assign x_d = kept ? OutCoordW'(qx) : '0;
  assign y_d = kept ? OutCoordW'(qy) : '0;
  assign z_d = kept ? depth2_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (en.s2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      depth1_q <= in_depth;
      rgb1_q   <= in_rgb;
    end
    if (en.s2) begin
      depth2_q <= depth1_q;
      rgb2_q   <= rgb1_q;
    end
    if (en3) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      rgb3_q <= rgb2_q;
      kept_q <= kept;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {rgb3_q, z_q, y_q, x_q};
  assign m_axis_tuser_o  = kept_q;

endmodule

@@ rtl/core/dpbp_checker.sv @@
`include "depth_pixel_backprojection_defines.svh"

module dpbp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [103:0] m_axis_tdata_o,
  input logic [0:0]   m_axis_tuser_o
);

  // Rejected points carry zero coordinates.
  `DPBP_ASSERT(a_reject_zero, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[79:0] == '0)

  // A kept point always has nonzero depth.
  `DPBP_ASSERT(a_kept_depth, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[79:64] != '0)

  // With the output side empty the input side must be open.
  `DPBP_ASSERT_MSG(a_ready_when_empty, clk_i, rst_ni,
    !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with empty output")

  // A stalled result holds.
  `DPBP_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))

endmodule

bind depth_pixel_backprojection dpbp_checker u_dpbp_checker (.*);
